// ----- hw/rtl/rbf_pkg.sv -----
// Shared types, constants and the 2^(-k/16) fraction table for the RBF kernel core.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package rbf_pkg;

	localparam int SUM_W      = 39;
	localparam int IDX_W      = 10;
	localparam int GAMMA_W    = 24;
	localparam int KVAL_W     = 17;
	localparam int FIFO_DEPTH = 2;

	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [16:0]      LOG2E_Q16 = 17'd94548;
	localparam logic [15:0]      LN2_Q16   = 16'd45426;
	localparam logic [16:0]      ONE_Q16   = 17'd65536;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd65536;

	// Configuration register indexes (word addresses).
	localparam logic REG_GAMMA = 1'b0;

	typedef struct packed {
		logic signed [15:0] x_feature;
		logic signed [15:0] y_feature;
		logic               last_feature;
		logic [IDX_W-1:0]   row_index;
		logic [IDX_W-1:0]   col_index;
	} rbf_in_t;

	typedef struct packed {
		logic [KVAL_W-1:0] kernel_value;
		logic [IDX_W-1:0]  out_row;
		logic [IDX_W-1:0]  out_col;
	} rbf_out_t;

	// One finished distance sum waiting for the exponential unit.
	typedef struct packed {
		logic [SUM_W-1:0] distance;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} rbf_job_t;

	function automatic logic [16:0] exp2_frac(input logic [3:0] k);
		logic [16:0] v;
		case (k)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd62757;
			4'd2:  v = 17'd60097;
			4'd3:  v = 17'd57549;
			4'd4:  v = 17'd55109;
			4'd5:  v = 17'd52773;
			4'd6:  v = 17'd50535;
			4'd7:  v = 17'd48393;
			4'd8:  v = 17'd46341;
			4'd9:  v = 17'd44376;
			4'd10: v = 17'd42495;
			4'd11: v = 17'd40693;
			4'd12: v = 17'd38968;
			4'd13: v = 17'd37316;
			4'd14: v = 17'd35734;
			4'd15: v = 17'd34219;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/rbf_accum.sv -----
// Front end: accepts feature pairs, squares the difference and accumulates the distance.
// Depends on rbf_pkg; hands finished sums to rbf_fifo.
`timescale 1ns / 1ps

module rbf_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             feat_valid,
	output logic             feat_ready,
	input  rbf_pkg::rbf_in_t feat,
	output logic             job_valid,
	input  logic             job_ready,
	output rbf_pkg::rbf_job_t job
);
	import rbf_pkg::*;

	logic                 s1_valid_q;
	logic [31:0]          sq_s1;
	logic                 last_s1;
	logic [IDX_W-1:0]     row_s1;
	logic [IDX_W-1:0]     col_s1;
	logic [SUM_W-1:0]     sum_q;

	logic signed [16:0]   diff;
	logic [15:0]          mag;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum_sat;
	logic                 s1_go;
	logic                 take;

	assign diff = 17'(feat.x_feature) - 17'(feat.y_feature);
	assign mag  = diff[16] ? 16'(-diff) : diff[15:0];

	assign sum_wide = {1'b0, sum_q} + {8'd0, sq_s1};
	assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

	// A last feature can only leave stage 1 when the queue has room.
	assign s1_go      = s1_valid_q && (!last_s1 || job_ready);
	assign feat_ready = !s1_valid_q || s1_go;
	assign take       = feat_valid && feat_ready;

	assign job_valid    = s1_valid_q && last_s1;
	assign job.distance = sum_sat;
	assign job.row      = row_s1;
	assign job.col      = col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			sum_q      <= '0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				sum_q <= last_s1 ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sq_s1   <= mag * mag;
			last_s1 <= feat.last_feature;
			row_s1  <= feat.row_index;
			col_s1  <= feat.col_index;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> sum_q == '0)
		else $error("distance sum not cleared after a last feature");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!feat_ready |-> s1_valid_q && last_s1 && !job_ready)
		else $error("front stalled without a blocked last feature");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_go |=> $stable(sum_q))
		else $error("distance sum changed without a feature");

endmodule

// ----- hw/rtl/rbf_fifo.sv -----
// Short register queue of finished distance sums between front and back end.
// Depends on rbf_pkg for the job type.
`timescale 1ns / 1ps

module rbf_fifo #(
	parameter int DEPTH = rbf_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  rbf_pkg::rbf_job_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rbf_pkg::rbf_job_t pop_data
);
	import rbf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rbf_job_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");

	a_count_both: assert property (@(posedge clk) disable iff (!arst_n)
		push && pop |=> $stable(count_q))
		else $error("queue count moved on a simultaneous push and pop");

endmodule

// ----- hw/rtl/rbf_exp.sv -----
// Back end: gamma times distance sum, exp(-t) in Q1.16; one step a cycle unless stalled.
// Depends on rbf_pkg for types, constants and the fraction table.
`timescale 1ns / 1ps

module rbf_exp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rbf_pkg::GAMMA_W-1:0]   gamma,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  rbf_pkg::rbf_job_t             job,
	output logic                          kern_valid,
	input  logic                          kern_ready,
	output rbf_pkg::rbf_out_t             kern
);
	import rbf_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL_LO = 4'd1;
	localparam logic [3:0] S_MUL_HI = 4'd2;
	localparam logic [3:0] S_ADD    = 4'd3;
	localparam logic [3:0] S_LOG    = 4'd4;
	localparam logic [3:0] S_POLY1  = 4'd5;
	localparam logic [3:0] S_POLY2  = 4'd6;
	localparam logic [3:0] S_MANT   = 4'd7;
	localparam logic [3:0] S_SHIFT  = 4'd8;

	logic [3:0]   state_q;
	rbf_job_t     job_q;
	logic [43:0]  pp_lo_q;
	logic [42:0]  pp_hi_q;
	logic         big_q;
	logic [20:0]  t_q;
	logic [4:0]   n_q;
	logic [15:0]  f_q;
	logic [11:0]  a_q;
	logic [16:0]  poly_q;
	logic [16:0]  m_q;
	logic         kern_valid_q;
	rbf_out_t     kern_q;

	logic [62:0]  prod_p;
	logic [36:0]  t_rnd;
	logic [37:0]  u_full;
	logic [27:0]  a_full;
	logic [24:0]  a_sq;
	logic [17:0]  poly_full;
	logic [33:0]  m_full;
	logic [17:0]  rnd;
	logic [17:0]  shifted;
	logic [16:0]  result;
	logic         load_out;

	assign prod_p    = {19'd0, pp_lo_q} + {pp_hi_q, 20'd0};
	assign t_rnd     = {1'b0, prod_p[35:0]} + 37'd32768;
	assign u_full    = t_q * LOG2E_Q16 + 38'd32768;
	assign a_full    = f_q[11:0] * LN2_Q16 + 28'd32768;
	assign a_sq      = a_q * a_q + 25'd65536;
	assign poly_full = {1'b0, ONE_Q16} - {6'd0, a_q} + {10'd0, a_sq[24:17]};
	assign m_full    = exp2_frac(f_q[15:12]) * poly_q + 34'd32768;

	// Rounded right shift by the integer part of the base-2 exponent.
	assign rnd     = {1'b0, m_q} + (18'd1 << (n_q - 5'd1));
	assign shifted = rnd >> n_q;

	always_comb begin
		if (big_q || n_q >= 5'd17) begin
			result = '0;
		end else if (n_q == 5'd0) begin
			result = m_q;
		end else begin
			result = shifted[16:0];
		end
	end

	assign job_ready  = state_q == S_IDLE;
	assign load_out   = (state_q == S_SHIFT) && (!kern_valid_q || kern_ready);
	assign kern_valid = kern_valid_q;
	assign kern       = kern_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kern_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				kern_valid_q <= 1'b1;
			end else if (kern_ready) begin
				kern_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_ADD;
				S_ADD:    state_q <= S_LOG;
				S_LOG:    state_q <= S_POLY1;
				S_POLY1:  state_q <= S_POLY2;
				S_POLY2:  state_q <= S_MANT;
				S_MANT:   state_q <= S_SHIFT;
				S_SHIFT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && job_valid) begin
			job_q <= job;
		end
		if (state_q == S_MUL_LO) begin
			pp_lo_q <= gamma * job_q.distance[19:0];
		end
		if (state_q == S_MUL_HI) begin
			pp_hi_q <= gamma * job_q.distance[SUM_W-1:20];
		end
		if (state_q == S_ADD) begin
			// Arguments of 16.0 or more give zero.
			big_q <= |prod_p[62:36];
			t_q   <= t_rnd[36:16];
		end
		if (state_q == S_LOG) begin
			n_q <= u_full[36:32];
			f_q <= u_full[31:16];
		end
		if (state_q == S_POLY1) begin
			a_q <= a_full[27:16];
		end
		if (state_q == S_POLY2) begin
			poly_q <= poly_full[16:0];
		end
		if (state_q == S_MANT) begin
			m_q <= m_full[32:16];
		end
		if (load_out) begin
			kern_q.kernel_value <= result;
			kern_q.out_row      <= job_q.row;
			kern_q.out_col      <= job_q.col;
		end
	end

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		kern_valid |-> kern.kernel_value <= ONE_Q16)
		else $error("kernel value above 1.0");

	a_big_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && big_q |=> kern.kernel_value == '0)
		else $error("large argument did not give zero");

	a_job_start: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> state_q == S_MUL_LO)
		else $error("exponential unit did not start on a taken job");

endmodule

// ----- hw/rtl/rbf_kernel_pair_core.sv -----
// Top level of the Gaussian RBF kernel core: APB gamma register, front end, queue, back end.
// Depends on rbf_pkg, rbf_accum, rbf_fifo and rbf_exp.
//
// Channel   Direction  Handshake             Transaction
// feat      in         feat_valid/feat_ready one feature pair of x and y
// kern      out        kern_valid/kern_ready one kernel value with row and column
// APB       in         psel/penable/pready   read or write of gamma
//
// The front end takes one feature pair every cycle; squaring and accumulation run in
// two stages, and a last feature waits only while the job queue is full.
// The exponential unit takes a job only when idle and forms two partial products of the
// 24 by 39 bit gamma multiply, then one multiply a cycle through the fraction evaluation.
// Vectors of nine or more features stream without stalls while kern_ready is held high.
// Reset clears the distance sum, the queue and all valid flags; gamma returns to 1.0.
`timescale 1ns / 1ps

module rbf_kernel_pair_core #(
	parameter int FIFO_DEPTH = rbf_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feat_valid,
	output logic              feat_ready,
	input  rbf_pkg::rbf_in_t  feat,
	output logic              kern_valid,
	input  logic              kern_ready,
	output rbf_pkg::rbf_out_t kern,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import rbf_pkg::*;

	logic [GAMMA_W-1:0] gamma_q;
	logic               push_valid;
	logic               push_ready;
	rbf_job_t           push_data;
	logic               pop_valid;
	logic               pop_ready;
	rbf_job_t           pop_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GAMMA) ? {8'd0, gamma_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAMMA) begin
			gamma_q <= pwdata[GAMMA_W-1:0];
		end
	end

	rbf_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.feat_valid (feat_valid),
		.feat_ready (feat_ready),
		.feat       (feat),
		.job_valid  (push_valid),
		.job_ready  (push_ready),
		.job        (push_data)
	);

	rbf_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rbf_exp u_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.gamma      (gamma_q),
		.job_valid  (pop_valid),
		.job_ready  (pop_ready),
		.job        (pop_data),
		.kern_valid (kern_valid),
		.kern_ready (kern_ready),
		.kern       (kern)
	);

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for rbf_kernel_pair_core: feature pairs in, kernel values out.
// Depends on rbf_pkg and the RTL of the core; it keeps its own fixed-point kernel predictor.
`timescale 1ns / 1ps

module testbench;
	import rbf_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_SHOWN     = 10;
	localparam logic [2:0] GAMMA_ADDR  = {REG_GAMMA, 2'b00};
	localparam logic [2:0] UNUSED_ADDR = 3'd4;
	localparam logic [63:0] LARGE_ARG  = 64'd16 << 32;
	localparam logic [16:0] FRAC_TAB [16] = '{
		17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773, 17'd50535, 17'd48393,
		17'd46341, 17'd44376, 17'd42495, 17'd40693, 17'd38968, 17'd37316, 17'd35734, 17'd34219
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        feat_valid;
	logic        feat_ready;
	rbf_in_t     feat;
	logic        kern_valid;
	logic        kern_ready;
	rbf_out_t    kern;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: the running squared distance and the gamma the core should hold.
	logic [SUM_W-1:0]   dist_acc;
	logic [GAMMA_W-1:0] gamma_now;
	rbf_out_t           kernel_queue[$];

	int  mismatches      = 0;
	int  pairs_sent      = 0;
	int  vectors_sent    = 0;
	int  kernels_checked = 0;
	int  gamma_settings  = 0;
	int  idle_cycles     = 0;
	bit  tx_gapless      = 1'b0;
	bit  rx_gapless      = 1'b0;

	rbf_kernel_pair_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.feat_valid(feat_valid),
		.feat_ready(feat_ready),
		.feat      (feat),
		.kern_valid(kern_valid),
		.kern_ready(kern_ready),
		.kern      (kern),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Adds the squared feature difference to the distance, saturating at the top of the range.
	function automatic logic [SUM_W-1:0] add_square(input logic [SUM_W-1:0] dsum,
			input logic signed [15:0] x, input logic signed [15:0] y);
		logic signed [16:0] diff;
		logic [16:0]        mag;
		logic [63:0]        total;
		diff  = {x[15], x} - {y[15], y};
		mag   = diff[16] ? 17'(-diff) : 17'(diff);
		total = 64'(dsum) + 64'(mag) * 64'(mag);
		if (total > 64'(SUM_MAX))
			total = 64'(SUM_MAX);
		return total[SUM_W-1:0];
	endfunction

	// exp(-gamma * dsum) in Q1.16 through base-2 range reduction and a fraction table.
	function automatic logic [KVAL_W-1:0] gauss_of_distance(input logic [SUM_W-1:0] dsum,
			input logic [GAMMA_W-1:0] g);
		logic [63:0] prod;
		logic [63:0] targ;
		logic [63:0] u2;
		logic [63:0] shift;
		logic [63:0] a;
		logic [63:0] poly;
		logic [63:0] mant;
		logic [15:0] frac;
		prod = 64'(g) * 64'(dsum);
		if (prod >= LARGE_ARG)
			return '0;
		targ  = (prod + 64'd32768) >> 16;
		u2    = (targ * 64'(LOG2E_Q16) + 64'd32768) >> 16;
		shift = u2 >> 16;
		frac  = u2[15:0];
		a     = (64'(frac[11:0]) * 64'(LN2_Q16) + 64'd32768) >> 16;
		poly  = 64'(ONE_Q16) - a + ((a * a + 64'd65536) >> 17);
		mant  = (64'(FRAC_TAB[frac[15:12]]) * poly + 64'd32768) >> 16;
		if (shift == 0)
			return mant[KVAL_W-1:0];
		if (shift >= 17)
			return '0;
		return KVAL_W'((mant + (64'd1 << (shift - 1))) >> shift);
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got)
			flag_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	// Sends one feature pair and updates the prediction when the transaction is accepted.
	task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic last, input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
		rbf_in_t  item;
		rbf_out_t want;
		int       gap;
		item.x_feature    = x;
		item.y_feature    = y;
		item.last_feature = last;
		item.row_index    = row;
		item.col_index    = col;
		gap = tx_gapless ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			feat_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feat       <= item;
		feat_valid <= 1'b1;
		do @(posedge clk); while (!(feat_valid && feat_ready));
		pairs_sent++;
		dist_acc = add_square(dist_acc, x, y);
		if (last) begin
			want.kernel_value = gauss_of_distance(dist_acc, gamma_now);
			want.out_row      = row;
			want.out_col      = col;
			kernel_queue.push_back(want);
			dist_acc = '0;
			vectors_sent++;
		end
	endtask

	// Holds the sender back until every predicted kernel value has come out.
	task automatic drain_results();
		feat_valid <= 1'b0;
		while (kernel_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB access followed by an idle bus phase, so back-to-back accesses never collide.
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes gamma with random upper bits, then reads it back.
	task automatic set_gamma(input logic [GAMMA_W-1:0] g);
		logic [31:0] rdata;
		logic [7:0]  junk;
		junk = 8'($urandom);
		apb_access(1'b1, GAMMA_ADDR, {junk, g}, rdata);
		gamma_now = g;
		gamma_settings++;
		apb_access(1'b0, GAMMA_ADDR, '0, rdata);
		check_field("gamma readback", 32'(gamma_now), 32'(rdata[GAMMA_W-1:0]));
	endtask

	task automatic test_gamma_register();
		logic [31:0] rdata;
		apb_access(1'b0, GAMMA_ADDR, '0, rdata);
		check_field("gamma after reset", 32'(GAMMA_RESET), 32'(rdata[GAMMA_W-1:0]));
		// A write beyond the gamma register must leave gamma alone.
		apb_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF, rdata);
		apb_access(1'b0, GAMMA_ADDR, '0, rdata);
		check_field("gamma after unused write", 32'(gamma_now), 32'(rdata[GAMMA_W-1:0]));
		set_gamma(24'h123456);
		set_gamma(GAMMA_RESET);
	endtask

	task automatic test_directed_pairs();
		send_pair(16'sd0, 16'sd0, 1'b1, 10'd0, 10'd0);
		send_pair(16'sd32767, -16'sd32768, 1'b1, 10'd1023, 10'd1023);
		send_pair(-16'sd32768, 16'sd32767, 1'b1, 10'd1023, 10'd0);
		send_pair(16'sd256, 16'sd0, 1'b1, 10'd0, 10'd1023);
		send_pair(16'sd128, 16'sd0, 1'b0, 10'd5, 10'd6);
		send_pair(16'sd0, -16'sd128, 1'b0, 10'd5, 10'd6);
		send_pair(-16'sd32768, -16'sd32768, 1'b1, 10'd5, 10'd6);
		send_pair(-16'sd1, 16'sd0, 1'b1, 10'h2AA, 10'h155);
		send_pair(16'sd32767, 16'sd32767, 1'b1, 10'h155, 10'h2AA);
		// A distance of exactly 16.0 sits on the large-argument boundary.
		send_pair(16'sd1024, 16'sd0, 1'b1, 10'd1, 10'd2);
		send_pair(16'sd1023, 16'sd0, 1'b1, 10'd3, 10'd4);
		send_pair(16'sd724, 16'sd0, 1'b1, 10'd7, 10'd8);
		send_pair(16'sh5555, 16'shAAAA, 1'b0, 10'd9, 10'd9);
		send_pair(16'shAAAA, 16'sh5555, 1'b1, 10'd9, 10'd9);
		send_pair(16'sd400, 16'sd37, 1'b1, 10'd11, 10'd12);
		drain_results();
		set_gamma('0);
		send_pair(16'sd32767, -16'sd32768, 1'b1, 10'd20, 10'd21);
		send_pair(16'sd100, 16'sd50, 1'b1, 10'd22, 10'd23);
		drain_results();
		set_gamma({GAMMA_W{1'b1}});
		send_pair(16'sd1, 16'sd0, 1'b1, 10'd24, 10'd25);
		send_pair(16'sd2, 16'sd0, 1'b1, 10'd26, 10'd27);
		send_pair(16'sd0, 16'sd0, 1'b1, 10'd28, 10'd29);
		drain_results();
	endtask

	// A vector far longer than the nominal feature count drives the distance into saturation;
	// with the smallest gamma a wrapped sum would give a nonzero value.
	task automatic test_distance_saturation();
		set_gamma(24'd1);
		repeat (130)
			send_pair(16'sd32767, -16'sd32768, 1'b0, 10'd0, 10'd0);
		send_pair(-16'sd32768, 16'sd32767, 1'b1, 10'd1000, 10'd999);
		drain_results();
	endtask

	task automatic test_random_stream(input int n_items, input logic [GAMMA_W-1:0] g);
		int          sent;
		int          len;
		int          k;
		int          paused;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] delta;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		set_gamma(g);
		sent   = 0;
		paused = 0;
		while (sent < n_items) begin
			if (sent % 64 < 8) begin
				tx_gapless = ($urandom_range(0, 3) == 0);
				rx_gapless = ($urandom_range(0, 3) == 0);
			end
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
			row = IDX_W'($urandom);
			col = IDX_W'($urandom);
			for (int i = 0; i < len; i++) begin
				x = 16'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					y = 16'($urandom);
				end else begin
					k     = $urandom_range(0, 11);
					delta = 16'($urandom_range(0, 1 << k));
					y     = $urandom_range(0, 1) ? x - delta : x + delta;
				end
				send_pair(x, y, i == len - 1, row, col);
				sent++;
			end
			if (!paused && sent > n_items / 2) begin
				drain_results();
				paused = 1;
			end
		end
		tx_gapless = 1'b0;
		rx_gapless = 1'b0;
		drain_results();
	endtask

	// Kernel output side: random back-pressure before each result.
	initial begin
		int stall;
		kern_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_gapless ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				kern_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			kern_ready <= 1'b1;
			do @(posedge clk); while (!(kern_valid && kern_ready));
		end
	end

	always @(posedge clk) begin
		rbf_out_t want;
		if (arst_n && kern_valid && kern_ready) begin
			kernels_checked++;
			if (kernel_queue.size() == 0) begin
				flag_mismatch($sformatf("unexpected kernel value %0d for row %0d col %0d",
					kern.kernel_value, kern.out_row, kern.out_col));
			end else begin
				want = kernel_queue.pop_front();
				check_field("kernel_value", 32'(want.kernel_value), 32'(kern.kernel_value));
				check_field("out_row", 32'(want.out_row), 32'(kern.out_row));
				check_field("out_col", 32'(want.out_col), 32'(kern.out_col));
			end
		end
	end

	// Ends the run if no transaction of any kind completes for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((feat_valid && feat_ready) || (kern_valid && kern_ready) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
					idle_cycles, kernel_queue.size());
				$display("rbf_kernel_pair_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		feat_valid <= 1'b0;
		feat       <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		dist_acc  = '0;
		gamma_now = GAMMA_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_gamma_register();
		test_directed_pairs();
		test_distance_saturation();
		test_random_stream(300, GAMMA_RESET);
		test_random_stream(300, GAMMA_W'($urandom_range(1, 8192)));
		test_random_stream(300, {GAMMA_W{1'b1}});
		test_random_stream(300, '0);
		test_random_stream(300, GAMMA_W'($urandom));
		test_random_stream(300, GAMMA_W'($urandom_range(8192, 131072)));

		mismatches += kernel_queue.size();
		$display("Sent %0d feature pairs in %0d vectors under %0d gamma writes;",
			pairs_sent, vectors_sent, gamma_settings);
		$display("checked %0d kernel values with %0d mismatches.", kernels_checked, mismatches);
		if (mismatches == 0) begin
			$display("rbf_kernel_pair_core verification clean");
		end else begin
			$display("rbf_kernel_pair_core verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/rbf_pkg.sv
hw/rtl/rbf_accum.sv
hw/rtl/rbf_fifo.sv
hw/rtl/rbf_exp.sv
hw/rtl/rbf_kernel_pair_core.sv
test/testbench.sv
